// ===== design/ddce_pkg.sv =====
// ----------------------------------------------------------------------------
// ddce_pkg
// Shared types, codes and frame builders for the dual drive CAN command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ddce_pkg;

    // input opcodes
    localparam logic [2:0] OP_ENABLE     = 3'd0;
    localparam logic [2:0] OP_DISABLE    = 3'd1;
    localparam logic [2:0] OP_SET_SPEED  = 3'd2;
    localparam logic [2:0] OP_READ_SPEED = 3'd3;
    localparam logic [2:0] OP_READ_POS   = 3'd4;
    localparam logic [2:0] OP_FRAME      = 3'd5;
    localparam logic [2:0] OP_TICK       = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_NODE     = 2'd0;
    localparam logic [1:0] CFG_RIGHT_NODE    = 2'd1;
    localparam logic [1:0] CFG_HOST_NODE     = 2'd2;
    localparam logic [1:0] CFG_REPLY_TIMEOUT = 2'd3;

    // request / reply function codes
    localparam logic [7:0] FN_CTRL_REQ   = 8'h24;
    localparam logic [7:0] FN_SPEED_REQ  = 8'h28;
    localparam logic [7:0] FN_RSPEED_REQ = 8'h0A;
    localparam logic [7:0] FN_RPOS_REQ   = 8'h0D;
    localparam logic [7:0] FN_CTRL_ACK   = 8'h25;
    localparam logic [7:0] FN_SPEED_ACK  = 8'h29;
    localparam logic [7:0] FN_RSPEED_ACK = 8'h0B;
    localparam logic [7:0] FN_RPOS_ACK   = 8'h0E;
    localparam logic [7:0] OBJ_CTRL      = 8'h10;
    localparam logic [7:0] OBJ_POS       = 8'h1D;

    localparam logic [10:0] TX_ID_BASE = 11'h100;
    localparam logic [3:0]  LEN_LONG   = 4'd6;
    localparam logic [3:0]  LEN_SHORT  = 4'd4;

    localparam int ACK_W = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = 1;
    localparam int QCNT_W      = 2;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic               is_report;
        logic [2:0]         op;
        logic [7:0]         host;
        logic [6:0]         left_node;
        logic [6:0]         right_node;
        logic [15:0]        left_speed;
        logic [15:0]        right_speed;
        logic               fail;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [47:0] build_payload(input logic [2:0] op,
                                                  input logic [7:0] host,
                                                  input logic [15:0] speed);
        logic [47:0] p;
        case (op)
            OP_ENABLE:     p = {host, FN_CTRL_REQ, 8'h00, OBJ_CTRL, 8'h00, 8'h01};
            OP_DISABLE:    p = {host, FN_CTRL_REQ, 8'h00, OBJ_CTRL, 8'h00, 8'h00};
            OP_SET_SPEED:  p = {host, FN_SPEED_REQ, 8'h00, 8'h00, speed};
            OP_READ_SPEED: p = {host, FN_RSPEED_REQ, 8'h00, 8'h00, 16'h0000};
            OP_READ_POS:   p = {host, FN_RPOS_REQ, 8'h00, OBJ_POS, 16'h0000};
            default:       p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] build_length(input logic [2:0] op);
        logic [3:0] len;
        case (op)
            OP_READ_SPEED, OP_READ_POS: len = LEN_SHORT;
            default:                    len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/ddce_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ddce_cmd_if
// Input channel: host commands, received frames and ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddce_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [15:0] left_speed_cmd;
    logic signed [15:0] right_speed_cmd;
    logic               rx_extended;
    logic               rx_remote;
    logic [63:0]        rx_payload;

    modport source (
        output valid, opcode, left_speed_cmd, right_speed_cmd,
               rx_extended, rx_remote, rx_payload,
        input  ready
    );
    modport sink (
        input  valid, opcode, left_speed_cmd, right_speed_cmd,
               rx_extended, rx_remote, rx_payload,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/ddce_res_if.sv =====
// ----------------------------------------------------------------------------
// ddce_res_if
// Output channel: request frames and completion reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddce_res_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [10:0]        tx_ident;
    logic [3:0]         tx_length;
    logic [47:0]        tx_payload;
    logic               fail;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;
    logic               last;

    modport source (
        output valid, kind, tx_ident, tx_length, tx_payload, fail,
               left_value, right_value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_ident, tx_length, tx_payload, fail,
               left_value, right_value, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/ddce_front.sv =====
// ----------------------------------------------------------------------------
// ddce_front
// Accepts beats, owns the protocol state and queues jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ddce_front
    import ddce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    ddce_cmd_if.sink        cmd,
    input  wire q_status_t  q_stat,
    output logic            q_push,
    output job_t            q_job
);

    logic [6:0]  left_node_reg;
    logic [6:0]  right_node_reg;
    logic [7:0]  host_node_reg;
    logic [15:0] reply_timeout_reg;

    logic [ACK_W-1:0] ack_reg,  ack_next;
    logic [2:0]       pending_reg, pending_next;
    logic             busy_reg, busy_next;
    logic [15:0]      wait_reg, wait_next;
    logic [15:0]      lspd_reg, lspd_next;
    logic [15:0]      rspd_reg, rspd_next;
    logic [31:0]      lpos_reg, lpos_next;
    logic [31:0]      rpos_reg, rpos_next;

    logic             accept;
    logic [7:0]       b [8];
    logic             hit_left, hit_right, side_r;
    logic [ACK_W-1:0] side;
    logic [ACK_W-1:0] pair;
    logic [15:0]      wait_inc;

    assign cmd.ready = !q_stat.full;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            b[i] = cmd.rx_payload[63 - 8*i -: 8];
        end
    end

    assign hit_left  = (b[0] == {1'b0, left_node_reg});
    assign hit_right = !hit_left && (b[0] == {1'b0, right_node_reg});
    assign side_r    = hit_right;
    assign side      = side_r ? ACK_W'(2'b10) : ACK_W'(2'b01);
    assign wait_inc  = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;

    always_comb
    begin
        ack_next     = ack_reg;
        pending_next = pending_reg;
        busy_next    = busy_reg;
        wait_next    = wait_reg;
        lspd_next    = lspd_reg;
        rspd_next    = rspd_reg;
        lpos_next    = lpos_reg;
        rpos_next    = rpos_reg;
        q_push       = 1'b0;
        pair         = '0;

        q_job             = '0;
        q_job.op          = cmd.opcode;
        q_job.host        = host_node_reg;
        q_job.left_node   = left_node_reg;
        q_job.right_node  = right_node_reg;
        q_job.left_speed  = cmd.left_speed_cmd;
        q_job.right_speed = cmd.right_speed_cmd;

        if (accept)
        begin
            case (cmd.opcode)
                OP_ENABLE, OP_DISABLE, OP_SET_SPEED, OP_READ_SPEED, OP_READ_POS:
                begin
                    if (!busy_reg)
                    begin
                        ack_next     = '0;
                        pending_next = cmd.opcode;
                        busy_next    = 1'b1;
                        wait_next    = '0;
                        q_push       = 1'b1;
                    end
                end
                OP_FRAME:
                begin
                    if (!cmd.rx_extended && !cmd.rx_remote && (hit_left || hit_right))
                    begin
                        // reply decode; flag pair of command c sits at bits 2c, 2c+1
                        case (b[1])
                            FN_CTRL_ACK:
                            begin
                                if (b[2] == 8'h00 && b[3] == OBJ_CTRL && b[4] == 8'h00)
                                begin
                                    if (b[5] == 8'h01)
                                        ack_next = ack_next | (side << (2 * OP_ENABLE));
                                    else if (b[5] == 8'h00)
                                        ack_next = ack_next | (side << (2 * OP_DISABLE));
                                end
                            end
                            FN_SPEED_ACK:
                            begin
                                if (b[2] == 8'h00 && b[3] == 8'h00)
                                    ack_next = ack_next | (side << (2 * OP_SET_SPEED));
                            end
                            FN_RSPEED_ACK:
                            begin
                                if (b[2] == 8'h00 && b[3] == 8'h00)
                                begin
                                    if (side_r)
                                        rspd_next = {b[4], b[5]};
                                    else
                                        lspd_next = {b[4], b[5]};
                                    ack_next = ack_next | (side << (2 * OP_READ_SPEED));
                                end
                            end
                            FN_RPOS_ACK:
                            begin
                                if (b[2] == 8'h00 && b[3] == OBJ_POS)
                                begin
                                    if (side_r)
                                        rpos_next = {b[6], b[7], b[4], b[5]};
                                    else
                                        lpos_next = {b[6], b[7], b[4], b[5]};
                                    ack_next = ack_next | (side << (2 * OP_READ_POS));
                                end
                            end
                            default:
                            begin
                            end
                        endcase

                        pair = ACK_W'(2'b11) << {pending_reg, 1'b0};
                        if (busy_reg && ((ack_next & pair) == pair))
                        begin
                            ack_next        = ack_next & ~pair;
                            busy_next       = 1'b0;
                            q_push          = 1'b1;
                            q_job.is_report = 1'b1;
                            if (pending_reg == OP_READ_SPEED)
                            begin
                                q_job.left_value  = {{16{lspd_next[15]}}, lspd_next};
                                q_job.right_value = {{16{rspd_next[15]}}, rspd_next};
                            end
                            else if (pending_reg == OP_READ_POS)
                            begin
                                q_job.left_value  = lpos_next;
                                q_job.right_value = rpos_next;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= reply_timeout_reg)
                        begin
                            busy_next       = 1'b0;
                            q_push          = 1'b1;
                            q_job.is_report = 1'b1;
                            q_job.fail      = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_node_reg     <= 7'd1;
            right_node_reg    <= 7'd2;
            host_node_reg     <= 8'd0;
            reply_timeout_reg <= 16'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_NODE:     left_node_reg     <= cfg_data[6:0];
                CFG_RIGHT_NODE:    right_node_reg    <= cfg_data[6:0];
                CFG_HOST_NODE:     host_node_reg     <= cfg_data[7:0];
                CFG_REPLY_TIMEOUT: reply_timeout_reg <= cfg_data;
                default:           reply_timeout_reg <= reply_timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_reg     <= '0;
            pending_reg <= '0;
            busy_reg    <= 1'b0;
            wait_reg    <= '0;
            lspd_reg    <= '0;
            rspd_reg    <= '0;
            lpos_reg    <= '0;
            rpos_reg    <= '0;
        end
        else
        begin
            ack_reg     <= ack_next;
            pending_reg <= pending_next;
            busy_reg    <= busy_next;
            wait_reg    <= wait_next;
            lspd_reg    <= lspd_next;
            rspd_reg    <= rspd_next;
            lpos_reg    <= lpos_next;
            rpos_reg    <= rpos_next;
        end
    end

    a_busy_rise_queued: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(q_push) && !$past(q_job.is_report))
        else $error("command started without queuing its frames");

    a_busy_fall_reported: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(q_push) && $past(q_job.is_report))
        else $error("command ended without a completion report");

endmodule

`default_nettype wire

// ===== design/ddce_queue.sv =====
// ----------------------------------------------------------------------------
// ddce_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ddce_queue
    import ddce_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire job_t  push_job,
    input  wire logic  pop,
    output job_t       head,
    output q_status_t  stat
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue overflow");

endmodule

`default_nettype wire

// ===== design/ddce_back.sv =====
// ----------------------------------------------------------------------------
// ddce_back
// Expands queued jobs into result beats through one output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddce_back
    import ddce_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_t      head,
    input  wire q_status_t q_stat,
    output logic           pop,
    ddce_res_if.source     res
);

    logic               valid_reg, valid_next;
    logic               phase_reg, phase_next;
    logic               kind_reg;
    logic [10:0]        ident_reg;
    logic [3:0]         len_reg;
    logic [47:0]        pay_reg;
    logic               fail_reg;
    logic signed [31:0] lval_reg;
    logic signed [31:0] rval_reg;
    logic               last_reg;

    logic load, take;

    assign load = !valid_reg || res.ready;
    assign take = load && !q_stat.empty;
    // a command job is two beats: left frame, then right frame
    assign pop  = take && (head.is_report || phase_reg);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
            valid_next = !q_stat.empty;
        if (take && !head.is_report)
            phase_next = !phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (head.is_report)
            begin
                kind_reg  <= 1'b1;
                ident_reg <= '0;
                len_reg   <= '0;
                pay_reg   <= '0;
                fail_reg  <= head.fail;
                lval_reg  <= head.left_value;
                rval_reg  <= head.right_value;
                last_reg  <= 1'b1;
            end
            else
            begin
                kind_reg  <= 1'b0;
                ident_reg <= TX_ID_BASE |
                    {4'b0000, (phase_reg ? head.right_node : head.left_node)};
                len_reg   <= build_length(head.op);
                pay_reg   <= build_payload(head.op, head.host,
                                 phase_reg ? head.right_speed : head.left_speed);
                fail_reg  <= 1'b0;
                lval_reg  <= '0;
                rval_reg  <= '0;
                last_reg  <= phase_reg;
            end
        end
    end

    assign res.valid       = valid_reg;
    assign res.kind        = kind_reg;
    assign res.tx_ident    = ident_reg;
    assign res.tx_length   = len_reg;
    assign res.tx_payload  = pay_reg;
    assign res.fail        = fail_reg;
    assign res.left_value  = lval_reg;
    assign res.right_value = rval_reg;
    assign res.last        = last_reg;

    a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_stat.empty)
        else $error("right frame pending with no job at queue head");

endmodule

`default_nettype wire

// ===== design/dual_drive_can_command_engine_unit.sv =====
// ----------------------------------------------------------------------------
// dual_drive_can_command_engine_unit
// Master side of the command/acknowledge exchange with two CAN wheel drives.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one beat per host command, received CAN frame or timer tick.
//   A command beat accepted while idle yields two request-frame beats on res
//   (left drive, then right drive, last set on the second). A frame or tick
//   that completes or times out the pending command yields one report beat.
//   Other beats yield nothing; commands arriving while busy are dropped.
//   The cfg port writes node numbers, host node and reply timeout; write it
//   only while no command is in flight.
// Timing:
//   An accepted job is written into the queue, then loaded into the output
//   register that drives res. Each job is drained by that register at one
//   beat per cycle while res is not stalled: two beats for a command, one
//   for a report.
// Reset:
//   Idle, all flags and captured values cleared, left node 1, right node 2,
//   host node 0, timeout 10 ticks.
// Stall:
//   While res is stalled the two-entry job queue fills; then cmd.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_drive_can_command_engine_unit
    import ddce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    ddce_cmd_if.sink         cmd,
    ddce_res_if.source       res
);

    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    job_t      q_job;
    job_t      q_head;

    ddce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    ddce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    ddce_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .res    (res)
    );

endmodule

`default_nettype wire
